>>> rtl/core/imm_pkg.sv
// shared constants and types for the integer matrix multiply core
package imm_pkg;

    // largest matrix dimension and derived index widths
    localparam int MAX_DIM = 8;
    localparam int DIM_W   = $clog2(MAX_DIM);
    localparam int ADDR_W  = 2 * DIM_W;

    // fixed field widths
    localparam int SIZE_W = 4;
    localparam int ELEM_W = 32;
    localparam int ACC_W  = 64;
    localparam int REQ_W  = 2;

    // size register value after reset
    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(MAX_DIM);

    // request codes
    localparam logic [REQ_W-1:0] REQ_LOAD_A  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_LOAD_B  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_COMPUTE = 2'd2;

    // one element of the A row travelling along the cell chain
    typedef struct packed {
        logic              valid;
        logic              first;
        logic              last;
        logic [DIM_W-1:0]  k;
        logic [ELEM_W-1:0] a;
    } link_t;

endpackage

>>> rtl/core/imm_req_if.sv
// request channel: element loads and row compute commands
interface imm_req_if;
    logic                                valid;
    logic                                ready;
    logic [imm_pkg::REQ_W-1:0]           req_type;
    logic [imm_pkg::DIM_W-1:0]           row;
    logic [imm_pkg::DIM_W-1:0]           col;
    logic signed [imm_pkg::ELEM_W-1:0]   element_value;

    modport source (output valid, output req_type, output row, output col,
                    output element_value, input ready);
    modport sink   (input valid, input req_type, input row, input col,
                    input element_value, output ready);
endinterface

>>> rtl/core/imm_res_if.sv
// result channel: one product element per transaction
interface imm_res_if;
    logic                               valid;
    logic                               ready;
    logic [imm_pkg::DIM_W-1:0]          out_row;
    logic [imm_pkg::DIM_W-1:0]          out_col;
    logic signed [imm_pkg::ACC_W-1:0]   product_value;
    logic                               last_of_row;

    modport source (output valid, output out_row, output out_col,
                    output product_value, output last_of_row, input ready);
    modport sink   (input valid, input out_row, input out_col,
                    input product_value, input last_of_row, output ready);
endinterface

>>> rtl/core/imm_mac_cell.sv
// one column cell: holds a column of B and accumulates one element of C
module imm_mac_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  imm_pkg::link_t                link_in,
    output imm_pkg::link_t                link_out,
    input  logic                          b_wr_en,
    input  logic [imm_pkg::DIM_W-1:0]     b_wr_addr,
    input  logic [imm_pkg::ELEM_W-1:0]    b_wr_data,
    input  logic                          clear,
    output logic [imm_pkg::ACC_W-1:0]     acc,
    output logic                          done
);

    logic [imm_pkg::ELEM_W-1:0]        col_reg [imm_pkg::MAX_DIM];
    logic [imm_pkg::ELEM_W-1:0]        b_rd;
    logic signed [imm_pkg::ELEM_W-1:0] a_s;
    logic signed [imm_pkg::ELEM_W-1:0] b_s;
    logic signed [imm_pkg::ACC_W-1:0]  prod_next;
    logic [imm_pkg::ACC_W-1:0]         prod_reg;
    logic                              pv_reg;
    logic                              pfirst_reg;
    logic                              plast_reg;
    logic [imm_pkg::ACC_W-1:0]         acc_reg;
    logic                              done_reg;
    imm_pkg::link_t                    link_reg;

    // column storage of B, one entry per k
    always_ff @(posedge clk)
    begin
        if (b_wr_en)
        begin
            col_reg[b_wr_addr] <= b_wr_data;
        end
    end

    // exact signed product of the passing A element and B[k][j]
    assign b_rd      = col_reg[link_in.k];
    assign a_s       = $signed(link_in.a);
    assign b_s       = $signed(b_rd);
    assign prod_next = a_s * b_s;

    // product stage flags, done flag and hand-off to the next cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_reg   <= '0;
            pv_reg     <= 1'b0;
            pfirst_reg <= 1'b0;
            plast_reg  <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            link_reg   <= link_in;
            pv_reg     <= link_in.valid;
            pfirst_reg <= link_in.first;
            plast_reg  <= link_in.last;
            if (clear)
            begin
                done_reg <= 1'b0;
            end
            else if (pv_reg && plast_reg)
            begin
                done_reg <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (link_in.valid)
        begin
            prod_reg <= prod_next;
        end
        if (pv_reg)
        begin
            acc_reg <= pfirst_reg ? prod_reg : (acc_reg + prod_reg);
        end
    end

    assign link_out = link_reg;
    assign acc      = acc_reg;
    assign done     = done_reg;

endmodule

>>> rtl/core/imm_row_feed.sv
// A matrix store and the sequencer that streams one row of A into the chain
module imm_row_feed (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [imm_pkg::ADDR_W-1:0]    wr_addr,
    input  logic [imm_pkg::ELEM_W-1:0]    wr_data,
    input  logic                          start,
    input  logic [imm_pkg::DIM_W-1:0]     row,
    input  logic [imm_pkg::DIM_W-1:0]     last_k,
    output logic                          busy,
    output imm_pkg::link_t                link_out
);

    logic [imm_pkg::ELEM_W-1:0] mem [imm_pkg::MAX_DIM * imm_pkg::MAX_DIM];
    logic [imm_pkg::ELEM_W-1:0] a_reg;
    logic [imm_pkg::DIM_W-1:0]  row_reg;
    logic [imm_pkg::DIM_W-1:0]  k_reg;
    logic [imm_pkg::DIM_W-1:0]  lastk_reg;
    logic                       busy_reg;
    logic                       lv_reg;
    logic                       lf_reg;
    logic                       ll_reg;
    logic [imm_pkg::DIM_W-1:0]  lk_reg;

    // A memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        a_reg <= mem[{row_reg, k_reg}];
    end

    // k sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            k_reg     <= '0;
            row_reg   <= '0;
            lastk_reg <= '0;
            lv_reg    <= 1'b0;
            lf_reg    <= 1'b0;
            ll_reg    <= 1'b0;
            lk_reg    <= '0;
        end
        else
        begin
            lv_reg <= busy_reg;
            lf_reg <= (k_reg == '0);
            ll_reg <= (k_reg == lastk_reg);
            lk_reg <= k_reg;
            if (start)
            begin
                busy_reg  <= 1'b1;
                k_reg     <= '0;
                row_reg   <= row;
                lastk_reg <= last_k;
            end
            else if (busy_reg)
            begin
                k_reg <= k_reg + 1'b1;
                if (k_reg == lastk_reg)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // element leaving the feed, aligned with the read data
    always_comb
    begin
        link_out.valid = lv_reg;
        link_out.first = lf_reg;
        link_out.last  = ll_reg;
        link_out.k     = lk_reg;
        link_out.a     = a_reg;
    end

    assign busy = busy_reg;

endmodule

>>> rtl/core/integer_matrix_multiply_core.sv
// top level of the integer matrix multiply core
//
// Computes rows of C = A * B for square matrices of size n = min(size, 8).
// The req channel carries transactions of three kinds: load an element of
// A, load an element of B, or compute a row of C. Loads give no result;
// loads outside n and compute of a row outside n are dropped.
// A compute streams row i of A, one element per cycle, along a chain of
// eight MAC cells, one per column of C; each cell keeps its column of B.
// After a compute is taken the core stays in RUN until the cell of the last
// column is done, then gives one result per cycle while the receiver is
// ready, for n columns, in column order, with last_of_row on the final one.
// A new request is taken only once the core is idle again and the tail of
// the row has left all eight cells; the core takes no request while it
// computes or emits a row. The final result sits in the output register
// while the next request is already taken. When the receiver stalls, results
// hold in the output register and the core waits; nothing is dropped.
// Reset clears the control state and sets the size to 8; matrix contents
// are undefined until written. Write the size only while the core is idle.
module integer_matrix_multiply_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [imm_pkg::SIZE_W-1:0]     cfg_wr_data,
    imm_req_if.sink                        req,
    imm_res_if.source                      res
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [imm_pkg::SIZE_W-1:0]  size_reg;
    logic [imm_pkg::SIZE_W-1:0]  n_eff;
    logic [imm_pkg::SIZE_W-1:0]  n_m1_full;
    logic [imm_pkg::DIM_W-1:0]   n_m1;
    logic [1:0]                  state_reg;
    logic [1:0]                  state_next;
    logic [imm_pkg::DIM_W-1:0]   row_reg;
    logic [imm_pkg::DIM_W-1:0]   last_reg;
    logic [imm_pkg::DIM_W-1:0]   col_reg;
    logic                        req_take;
    logic                        row_ok;
    logic                        elem_ok;
    logic                        a_wr;
    logic                        b_wr;
    logic                        start;
    logic                        feed_busy;
    logic                        chain_busy;
    logic                        out_load;
    logic                        out_valid_reg;
    logic [imm_pkg::DIM_W-1:0]   out_row_reg;
    logic [imm_pkg::DIM_W-1:0]   out_col_reg;
    logic [imm_pkg::ACC_W-1:0]   out_prod_reg;
    logic                        out_last_reg;
    imm_pkg::link_t              link_w [imm_pkg::MAX_DIM + 1];
    logic [imm_pkg::ACC_W-1:0]   acc_vec [imm_pkg::MAX_DIM];
    logic [imm_pkg::MAX_DIM-1:0] done_vec;

    // size register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= imm_pkg::SIZE_RESET;
        end
        else if (cfg_wr_en)
        begin
            size_reg <= cfg_wr_data;
        end
    end

    // effective size, saturated at the array dimension
    assign n_eff     = (size_reg > imm_pkg::SIZE_W'(imm_pkg::MAX_DIM))
                       ? imm_pkg::SIZE_W'(imm_pkg::MAX_DIM) : size_reg;
    assign n_m1_full = n_eff - imm_pkg::SIZE_W'(1);
    assign n_m1      = n_m1_full[imm_pkg::DIM_W-1:0];

    // any row element still travelling along the chain
    always_comb
    begin
        chain_busy = 1'b0;
        for (int i = 0; i <= imm_pkg::MAX_DIM; i++)
        begin
            chain_busy = chain_busy | link_w[i].valid;
        end
    end

    // request decode
    assign req.ready = (state_reg == ST_IDLE) && !chain_busy;
    assign req_take  = req.valid && req.ready;
    assign row_ok    = (imm_pkg::SIZE_W'(req.row) < n_eff);
    assign elem_ok   = row_ok && (imm_pkg::SIZE_W'(req.col) < n_eff);
    assign a_wr      = req_take && (req.req_type == imm_pkg::REQ_LOAD_A) && elem_ok;
    assign b_wr      = req_take && (req.req_type == imm_pkg::REQ_LOAD_B) && elem_ok;
    assign start     = req_take && (req.req_type == imm_pkg::REQ_COMPUTE) && row_ok;

    // A store and row sequencer
    imm_row_feed u_feed (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (a_wr),
        .wr_addr  ({req.row, req.col}),
        .wr_data  (req.element_value),
        .start    (start),
        .row      (req.row),
        .last_k   (n_m1),
        .busy     (feed_busy),
        .link_out (link_w[0])
    );

    // chain of column cells
    for (genvar j = 0; j < imm_pkg::MAX_DIM; j++)
    begin : g_cell
        imm_mac_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .link_in   (link_w[j]),
            .link_out  (link_w[j+1]),
            .b_wr_en   (b_wr && (req.col == imm_pkg::DIM_W'(j))),
            .b_wr_addr (req.row),
            .b_wr_data (req.element_value),
            .clear     (start),
            .acc       (acc_vec[j]),
            .done      (done_vec[j])
        );
    end

    // output register load while emitting
    assign out_load = (state_reg == ST_EMIT) && (!out_valid_reg || res.ready);

    // sequencer state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (done_vec[last_reg])
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_load && (col_reg == last_reg))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_reg       <= '0;
            last_reg      <= '0;
            col_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (start)
            begin
                row_reg  <= req.row;
                last_reg <= n_m1;
                col_reg  <= '0;
            end
            else if (out_load)
            begin
                col_reg <= col_reg + 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_row_reg  <= row_reg;
            out_col_reg  <= col_reg;
            out_prod_reg <= acc_vec[col_reg];
            out_last_reg <= (col_reg == last_reg);
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.out_row       = out_row_reg;
    assign res.out_col       = out_col_reg;
    assign res.product_value = $signed(out_prod_reg);
    assign res.last_of_row   = out_last_reg;

    // the last column cannot finish while the row is still being fed
    a_no_early_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN && feed_busy) |-> !done_vec[last_reg])
        else $error("last column finished before its row was fed");

    // emission never runs past the row length
    a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (col_reg <= last_reg))
        else $error("column counter beyond row length");

    // the final column is flagged and returns the core to idle
    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && col_reg == last_reg) |=> (res.last_of_row && state_reg == ST_IDLE))
        else $error("final column not flagged or core not idle");

endmodule

>>> sim/integer_matrix_multiply_core_test.sv
// self-checking testbench for the integer matrix multiply core
`timescale 1ns / 1ps

module integer_matrix_multiply_core_test;
    import imm_pkg::*;

    // request code the core does not use
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    // cycles the core may still be busy after its last product
    localparam int SETTLE_CYCLES = 40;
    localparam int TARGET_ITEMS  = 230;

    // one element of C as it leaves the core
    typedef struct packed {
        logic [DIM_W-1:0]        row_idx;
        logic [DIM_W-1:0]        col_idx;
        logic signed [ACC_W-1:0] dot;
        logic                    row_end;
    } product_t;

    // tracks A, B and the size, and holds the C elements still owed
    class row_product_tracker;
        logic signed [ELEM_W-1:0] a_elem [MAX_DIM*MAX_DIM];
        logic signed [ELEM_W-1:0] b_elem [MAX_DIM*MAX_DIM];
        bit                       a_set  [MAX_DIM*MAX_DIM];
        bit                       b_set  [MAX_DIM*MAX_DIM];
        logic [SIZE_W-1:0]        size_reg;
        product_t                 owed_products[$];
        int                       mismatch_count;

        function new();
            size_reg = SIZE_RESET;
            mismatch_count = 0;
            foreach (a_set[i])
            begin
                a_set[i] = 0;
                b_set[i] = 0;
            end
        endfunction

        function int dim();
            return (size_reg > MAX_DIM) ? MAX_DIM : int'(size_reg);
        endfunction

        function void set_size(logic [SIZE_W-1:0] v);
            size_reg = v;
        endfunction

        function int pending();
            return owed_products.size();
        endfunction

        // true when every entry a compute of this row reads has been loaded
        function bit row_ready(int r);
            int n;
            n = dim();
            for (int k = 0; k < n; k++)
            begin
                if (!a_set[r*MAX_DIM+k])
                    return 0;
                for (int j = 0; j < n; j++)
                    if (!b_set[k*MAX_DIM+j])
                        return 0;
            end
            return 1;
        endfunction

        // update the matrices or queue the products of one accepted transaction
        function void note_request(logic [REQ_W-1:0] kind, logic [DIM_W-1:0] r,
                                   logic [DIM_W-1:0] c, logic signed [ELEM_W-1:0] v);
            int n;
            product_t p;
            logic signed [ACC_W-1:0] acc;
            logic signed [ACC_W-1:0] wa;
            logic signed [ACC_W-1:0] wb;
            n = dim();
            if (kind == REQ_LOAD_A || kind == REQ_LOAD_B)
            begin
                if (int'(r) < n && int'(c) < n)
                begin
                    if (kind == REQ_LOAD_A)
                    begin
                        a_elem[int'(r)*MAX_DIM+int'(c)] = v;
                        a_set[int'(r)*MAX_DIM+int'(c)] = 1;
                    end
                    else
                    begin
                        b_elem[int'(r)*MAX_DIM+int'(c)] = v;
                        b_set[int'(r)*MAX_DIM+int'(c)] = 1;
                    end
                end
            end
            else if (kind == REQ_COMPUTE && int'(r) < n)
            begin
                for (int j = 0; j < n; j++)
                begin
                    acc = '0;
                    for (int k = 0; k < n; k++)
                    begin
                        wa = a_elem[int'(r)*MAX_DIM+k];
                        wb = b_elem[k*MAX_DIM+j];
                        acc = acc + wa * wb;
                    end
                    p.row_idx = r;
                    p.col_idx = DIM_W'(j);
                    p.dot     = acc;
                    p.row_end = (j == n - 1);
                    owed_products.push_back(p);
                end
            end
        endfunction

        // compare one product from the core with the oldest one owed
        function void check_result(logic [DIM_W-1:0] r, logic [DIM_W-1:0] c,
                                   logic signed [ACC_W-1:0] v, logic e);
            product_t want;
            if (owed_products.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: unexpected product row %0d col %0d value %0d last %0b",
                             $realtime, r, c, v, e);
            end
            else
            begin
                want = owed_products.pop_front();
                if (want.row_idx !== r || want.col_idx !== c || want.dot !== v ||
                    want.row_end !== e)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"%0t: mismatch expected row %0d col %0d value %0d ",
                                  "last %0b, got row %0d col %0d value %0d last %0b"},
                                 $realtime, want.row_idx, want.col_idx, want.dot,
                                 want.row_end, r, c, v, e);
                end
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [SIZE_W-1:0] cfg_wr_data;

    imm_req_if req_ch();
    imm_res_if res_ch();

    integer_matrix_multiply_core u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_ch),
        .res         (res_ch)
    );

    row_product_tracker tracker = new();

    int sent_items   = 0;
    bit sender_calm  = 0;
    int stall_left   = 0;
    int mood_left    = 0;
    bit sink_calm    = 0;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // overall time limit
    initial
    begin
        #4_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // result receiver: ready with random stalls, calm stretches now and then
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (mood_left == 0)
            begin
                mood_left = $urandom_range(30, 120);
                sink_calm = ($urandom_range(0, 2) == 0);
            end
            mood_left--;
            if (stall_left > 0)
            begin
                stall_left--;
                res_ch.ready = 1'b0;
            end
            else if (!sink_calm && $urandom_range(0, 9) < 3)
            begin
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                         : $urandom_range(0, 2);
                res_ch.ready = 1'b0;
            end
            else
                res_ch.ready = 1'b1;
        end
    end

    // check every result transaction
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
            tracker.check_result(res_ch.out_row, res_ch.out_col, res_ch.product_value,
                                 res_ch.last_of_row);
    end

    // element values lean towards the extremes
    function automatic logic signed [ELEM_W-1:0] pick_element();
        case ($urandom_range(0, 9))
            0: return {1'b1, {(ELEM_W-1){1'b0}}};
            1: return {1'b0, {(ELEM_W-1){1'b1}}};
            2: return '1;
            3: return '0;
            default: return $urandom;
        endcase
    endfunction

    // mostly short gaps, a few long ones, none in a calm phase
    function automatic int sender_gap();
        int p;
        p = $urandom_range(0, 99);
        if (sender_calm || p < 60)
            return 0;
        else if (p < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 30);
    endfunction

    // drive one request transaction and wait for it to be taken
    task automatic issue_request(input logic [REQ_W-1:0] kind, input int r, input int c,
                                 input logic signed [ELEM_W-1:0] v);
        int gap;
        @(negedge clk);
        req_ch.valid         = 1'b1;
        req_ch.req_type      = kind;
        req_ch.row           = DIM_W'(r);
        req_ch.col           = DIM_W'(c);
        req_ch.element_value = v;
        do
            @(posedge clk);
        while (!req_ch.ready);
        tracker.note_request(kind, DIM_W'(r), DIM_W'(c), v);
        sent_items++;
        gap = sender_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            req_ch.valid = 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // hold off the sender until every owed product has arrived
    task automatic wait_for_products();
        @(negedge clk);
        req_ch.valid = 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
    endtask

    task automatic settle_and_idle();
        wait_for_products();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // size register write, only while the core is idle
    task automatic set_matrix_size(input logic [SIZE_W-1:0] v);
        @(negedge clk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = v;
        @(posedge clk);
        tracker.set_size(v);
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    // one configuration setting: fill what is missing, then a random mix
    task automatic run_phase(input logic [SIZE_W-1:0] size_val, input int budget);
        int n;
        int done;
        int p;
        int r;
        int c;
        settle_and_idle();
        set_matrix_size(size_val);
        n = tracker.dim();
        sender_calm = ($urandom_range(0, 3) == 0);
        if (n == 0)
        begin
            // nothing is in range, so every transaction is dropped
            repeat (6)
                issue_request(REQ_W'($urandom_range(0, 3)), $urandom_range(0, 7),
                              $urandom_range(0, 7), pick_element());
        end
        else
        begin
            // load every entry a compute could read that was never loaded
            for (r = 0; r < n; r++)
                for (c = 0; c < n; c++)
                begin
                    if (!tracker.a_set[r*MAX_DIM+c])
                        issue_request(REQ_LOAD_A, r, c, pick_element());
                    if (!tracker.b_set[r*MAX_DIM+c])
                        issue_request(REQ_LOAD_B, r, c, pick_element());
                end
            done = 0;
            while (done < budget)
            begin
                p = $urandom_range(0, 99);
                if (p < 50)
                begin
                    r = $urandom_range(0, n - 1);
                    if (tracker.row_ready(r))
                    begin
                        issue_request(REQ_COMPUTE, r, $urandom_range(0, 7), pick_element());
                        done++;
                    end
                end
                else if (p < 80)
                begin
                    issue_request(REQ_W'($urandom_range(0, 1)), $urandom_range(0, n - 1),
                                  $urandom_range(0, n - 1), pick_element());
                    done++;
                end
                else if (p < 88 && n < MAX_DIM)
                begin
                    // load with row or column past the size in use
                    if ($urandom_range(0, 1) == 0)
                    begin
                        r = $urandom_range(n, MAX_DIM - 1);
                        c = $urandom_range(0, MAX_DIM - 1);
                    end
                    else
                    begin
                        r = $urandom_range(0, MAX_DIM - 1);
                        c = $urandom_range(n, MAX_DIM - 1);
                    end
                    issue_request(REQ_W'($urandom_range(0, 1)), r, c, pick_element());
                end
                else if (p < 94 && n < MAX_DIM)
                    issue_request(REQ_COMPUTE, $urandom_range(n, MAX_DIM - 1),
                                  $urandom_range(0, 7), pick_element());
                else
                    issue_request(REQ_UNUSED, $urandom_range(0, 7), $urandom_range(0, 7),
                                  pick_element());
                if ($urandom_range(0, 19) == 0)
                    wait_for_products();
            end
        end
    endtask

    // main sequence
    initial
    begin
        rst_n                = 1'b0;
        cfg_wr_en            = 1'b0;
        cfg_wr_data          = '0;
        req_ch.valid         = 1'b0;
        req_ch.req_type      = REQ_LOAD_A;
        req_ch.row           = '0;
        req_ch.col           = '0;
        req_ch.element_value = '0;
        res_ch.ready         = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // at the reset size the far corner is in range
        issue_request(REQ_LOAD_A, 7, 7, {1'b0, {(ELEM_W-1){1'b1}}});
        issue_request(REQ_LOAD_B, 7, 7, {1'b1, {(ELEM_W-1){1'b0}}});
        issue_request(REQ_UNUSED, 7, 7, '1);

        // two by two: extremes, wrap of the sum past the top of 64 bits
        settle_and_idle();
        set_matrix_size(SIZE_W'(2));
        issue_request(REQ_LOAD_A, 0, 0, {1'b1, {(ELEM_W-1){1'b0}}});
        issue_request(REQ_LOAD_A, 0, 1, {1'b1, {(ELEM_W-1){1'b0}}});
        issue_request(REQ_LOAD_A, 1, 0, {1'b0, {(ELEM_W-1){1'b1}}});
        issue_request(REQ_LOAD_A, 1, 1, '1);
        issue_request(REQ_LOAD_B, 0, 0, {1'b1, {(ELEM_W-1){1'b0}}});
        issue_request(REQ_LOAD_B, 1, 0, {1'b1, {(ELEM_W-1){1'b0}}});
        issue_request(REQ_LOAD_B, 0, 1, {1'b0, {(ELEM_W-1){1'b1}}});
        issue_request(REQ_LOAD_B, 1, 1, '0);
        issue_request(REQ_COMPUTE, 0, 0, '0);
        issue_request(REQ_COMPUTE, 1, 7, '1);
        wait_for_products();

        // loads and computes past the size in use, the unused code, then a row in range
        issue_request(REQ_LOAD_A, 1, 5, $urandom);
        issue_request(REQ_LOAD_B, 6, 0, $urandom);
        issue_request(REQ_COMPUTE, 2, 0, '0);
        issue_request(REQ_COMPUTE, 7, 7, '1);
        issue_request(REQ_UNUSED, 0, 0, '0);
        issue_request(REQ_COMPUTE, 1, 0, '0);

        // random part across sizes, saturation and zero among them
        run_phase(SIZE_W'(1), 20);
        run_phase(SIZE_W'(3), 20);
        run_phase(SIZE_W'(15), 15);
        run_phase(SIZE_W'(0), 0);
        run_phase(SIZE_W'(9), 15);
        while (sent_items < TARGET_ITEMS)
            run_phase(($urandom_range(0, 3) == 0) ? SIZE_W'($urandom_range(5, 8))
                                                  : SIZE_W'($urandom_range(1, 4)), 15);

        settle_and_idle();
        if (tracker.mismatch_count == 0 && tracker.pending() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

>>> integer_matrix_multiply_core.f
rtl/core/imm_pkg.sv
rtl/core/imm_req_if.sv
rtl/core/imm_res_if.sv
rtl/core/imm_mac_cell.sv
rtl/core/imm_row_feed.sv
rtl/core/integer_matrix_multiply_core.sv
sim/integer_matrix_multiply_core_test.sv
